[rtl/mfef_pkg.sv]
package mfef_pkg;

   localparam int unsigned MaxVlqBytes = 4;
   localparam int unsigned VlqCntW     = $clog2(MaxVlqBytes + 1);

   localparam logic [7:0] SysexF0 = 8'hF0;
   localparam logic [7:0] SysexF7 = 8'hF7;
   localparam logic [7:0] MetaFF  = 8'hFF;

   typedef enum logic [1:0] {
      KIND_CHAN3 = 2'd0,
      KIND_CHAN2 = 2'd1,
      KIND_SYSEX = 2'd2,
      KIND_META  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE    = 2'd0,
      ERR_STATUS  = 2'd1,
      ERR_VLQ_LEN = 2'd2
   } err_type;

   typedef struct packed {
      logic [7:0]  echo_byte;
      logic        event_start;
      logic        event_end;
      logic [1:0]  event_kind;
      logic [28:0] event_length;
      logic [1:0]  error_code;
   } result_type;

endpackage

[rtl/mfef_in_reg.sv]
module mfef_in_reg (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   output logic       item_valid,
   output logic [7:0] item_byte,
   input  logic       item_take
);
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;

   assign req_ready = !valid_ff || item_take;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !item_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && req_ready) begin
         byte_ff <= req_data_byte;
      end
   end

   assign item_valid = valid_ff;
   assign item_byte  = byte_ff;
endmodule

[rtl/mfef_step.sv]
module mfef_step (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic [7:0]            data_byte,
   output mfef_pkg::result_type  result
);
   import mfef_pkg::*;

   typedef enum logic [2:0] {
      PH_WAIT = 3'd0,
      PH_CHAN = 3'd1,
      PH_TYPE = 3'd2,
      PH_VLQ  = 3'd3,
      PH_DATA = 3'd4
   } phase_type;

   phase_type            phase_ff, phase_in;
   kind_type             kind_ff, kind_in;
   logic [27:0]          left_ff, left_in;
   logic [VlqCntW-1:0]   vcnt_ff, vcnt_in;
   logic [27:0]          vacc_ff, vacc_in;
   logic [28:0]          len_ff, len_in;
   logic [27:0]          left_dec;
   logic [VlqCntW:0]     vcnt_inc;
   logic                 start, fin;
   err_type              err;

   assign left_dec = left_ff - 28'd1;
   assign vcnt_inc = {1'b0, vcnt_ff} + {{VlqCntW{1'b0}}, 1'b1};

   always_comb begin
      phase_in = phase_ff;
      kind_in  = kind_ff;
      left_in  = left_ff;
      vcnt_in  = vcnt_ff;
      vacc_in  = vacc_ff;
      len_in   = len_ff;
      start    = 1'b0;
      fin      = 1'b0;
      err      = ERR_NONE;
      case (phase_ff)
         PH_WAIT: begin
            start   = 1'b1;
            len_in  = 29'd1;
            vcnt_in = '0;
            vacc_in = '0;
            case (data_byte[7:4])
               4'h8, 4'h9, 4'hA, 4'hB, 4'hE: begin
                  kind_in  = KIND_CHAN3;
                  left_in  = 28'd2;
                  phase_in = PH_CHAN;
               end
               4'hC, 4'hD: begin
                  kind_in  = KIND_CHAN2;
                  left_in  = 28'd1;
                  phase_in = PH_CHAN;
               end
               default: begin
                  if (data_byte == SysexF0 || data_byte == SysexF7) begin
                     kind_in  = KIND_SYSEX;
                     phase_in = PH_VLQ;
                  end else if (data_byte == MetaFF) begin
                     kind_in  = KIND_META;
                     phase_in = PH_TYPE;
                  end else begin
                     // dropped byte: state held
                     err      = ERR_STATUS;
                     start    = 1'b0;
                     len_in   = len_ff;
                     vcnt_in  = vcnt_ff;
                     vacc_in  = vacc_ff;
                  end
               end
            endcase
         end
         PH_CHAN, PH_DATA: begin
            len_in  = len_ff + 29'd1;
            left_in = left_dec;
            if (left_dec == '0) begin
               fin      = 1'b1;
               phase_in = PH_WAIT;
            end
         end
         PH_TYPE: begin
            len_in   = len_ff + 29'd1;
            phase_in = PH_VLQ;
         end
         PH_VLQ: begin
            len_in  = len_ff + 29'd1;
            vacc_in = {vacc_ff[20:0], data_byte[6:0]};
            if (!data_byte[7]) begin
               vcnt_in = '0;
               if (vacc_in == '0) begin
                  fin      = 1'b1;
                  phase_in = PH_WAIT;
               end else begin
                  left_in  = vacc_in;
                  phase_in = PH_DATA;
               end
            end else if (vcnt_inc >= (VlqCntW + 1)'(MaxVlqBytes)) begin
               err      = ERR_VLQ_LEN;
               phase_in = PH_WAIT;
               vcnt_in  = '0;
            end else begin
               vcnt_in = vcnt_inc[VlqCntW-1:0];
            end
         end
         default: begin
            len_in   = len_ff + 29'd1;
            phase_in = PH_WAIT;
         end
      endcase
   end

   always_comb begin
      if (err == ERR_STATUS) begin
         result            = '0;
         result.error_code = ERR_STATUS;
      end else begin
         result.echo_byte    = data_byte;
         result.event_start  = start;
         result.event_end    = fin;
         result.event_kind   = kind_in;
         result.event_length = len_in;
         result.error_code   = err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         kind_ff  <= KIND_CHAN3;
         left_ff  <= '0;
         vcnt_ff  <= '0;
         vacc_ff  <= '0;
         len_ff   <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
         left_ff  <= left_in;
         vcnt_ff  <= vcnt_in;
         vacc_ff  <= vacc_in;
         len_ff   <= len_in;
      end
   end
endmodule

[rtl/mfef_out_reg.sv]
module mfef_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load_valid,
   output logic                  load_ready,
   input  mfef_pkg::result_type  load_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output mfef_pkg::result_type  rsp_data
);
   import mfef_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign load_ready = !valid_ff || rsp_ready;
   assign valid_in   = (load_valid && load_ready) || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load_valid && load_ready) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;
endmodule

[rtl/midi_file_event_framer_top.sv]
// MIDI file event framer.
// Input: one raw event byte per item on req_* (valid/ready). Events are back
// to back with no delta times. Output: one item per input byte on rsp_*,
// carrying the echoed byte, start/end marks, event kind, running length and
// an error code. Bad status bytes return error 1 with all other fields zero;
// an over-long length VLQ returns error 2 and framing resumes at a status byte.
// Path: an accepted byte passes two register stages (input register, then
// result register) before it shows on rsp_*.
// Throughput: one byte per cycle unless rsp_ready stalls; the framing state
// update is one pass of decode plus a 29-bit increment between the registers.
// Reset (synchronous, active high) empties both stages and returns the framer
// to waiting for a status byte.
// Stall: when rsp_ready is low the result register holds, the input register
// fills, and req_ready drops once both hold an item; nothing is lost.
module midi_file_event_framer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_echo_byte,
   output logic        rsp_event_start,
   output logic        rsp_event_end,
   output logic [1:0]  rsp_event_kind,
   output logic [28:0] rsp_event_length,
   output logic [1:0]  rsp_error_code
);
   import mfef_pkg::*;

   logic       item_valid;
   logic [7:0] item_byte;
   logic       load_ready;
   logic       take;
   result_type step_res;
   result_type out_res;

   assign take = item_valid && load_ready;

   mfef_in_reg u_in (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .item_valid    (item_valid),
      .item_byte     (item_byte),
      .item_take     (take)
   );

   mfef_step u_step (
      .clock     (clock),
      .reset     (reset),
      .advance   (take),
      .data_byte (item_byte),
      .result    (step_res)
   );

   mfef_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load_valid (item_valid),
      .load_ready (load_ready),
      .load_data  (step_res),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (out_res)
   );

   assign rsp_echo_byte    = out_res.echo_byte;
   assign rsp_event_start  = out_res.event_start;
   assign rsp_event_end    = out_res.event_end;
   assign rsp_event_kind   = out_res.event_kind;
   assign rsp_event_length = out_res.event_length;
   assign rsp_error_code   = out_res.error_code;
endmodule

[tb/sv/midi_frame_monitor.sv]
module midi_frame_monitor
   import mfef_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_echo_byte,
   input  logic        rsp_event_start,
   input  logic        rsp_event_end,
   input  logic [1:0]  rsp_event_kind,
   input  logic [28:0] rsp_event_length,
   input  logic [1:0]  rsp_error_code,
   output int          mismatch_count,
   output int          waiting_count
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [3:0] NoteOff   = 4'h8;
   localparam logic [3:0] NoteOn    = 4'h9;
   localparam logic [3:0] PolyTouch = 4'hA;
   localparam logic [3:0] Control   = 4'hB;
   localparam logic [3:0] Program   = 4'hC;
   localparam logic [3:0] ChanTouch = 4'hD;
   localparam logic [3:0] PitchBend = 4'hE;

   typedef enum logic [2:0] {
      AWAIT_STATUS,
      CHAN_BYTES,
      META_TYPE,
      LEN_VLQ,
      BODY_BYTES
   } frame_phase_type;

   frame_phase_type phase;
   kind_type     kind_q;
   logic [27:0]  left_q;
   logic [27:0]  vlq_acc;
   logic [2:0]   vlq_seen;
   logic [28:0]  len_q;

   result_type   framed_q[$];
   result_type   want;
   int           mismatches = 0;
   int           waiting = 0;

   assign mismatch_count = mismatches;
   assign waiting_count  = waiting;

   function automatic result_type frame_byte(input logic [7:0] b);
      result_type r;
      r = '0;
      r.echo_byte = b;
      r.error_code = ERR_NONE;
      if (phase == AWAIT_STATUS) begin
         case (b[7:4])
            NoteOff, NoteOn, PolyTouch, Control, PitchBend: begin
               kind_q = KIND_CHAN3;
               left_q = 28'd2;
               phase = CHAN_BYTES;
            end
            Program, ChanTouch: begin
               kind_q = KIND_CHAN2;
               left_q = 28'd1;
               phase = CHAN_BYTES;
            end
            default: begin
               if (b == SysexF0 || b == SysexF7) begin
                  kind_q = KIND_SYSEX;
                  phase = LEN_VLQ;
               end else if (b == MetaFF) begin
                  kind_q = KIND_META;
                  phase = META_TYPE;
               end else begin
                  // bad status: dropped, state untouched
                  r = '0;
                  r.error_code = ERR_STATUS;
                  return r;
               end
            end
         endcase
         r.event_start = 1'b1;
         len_q = 29'd1;
         vlq_seen = '0;
         vlq_acc = '0;
      end else begin
         len_q = len_q + 29'd1;
         case (phase)
            CHAN_BYTES, BODY_BYTES: begin
               left_q = left_q - 28'd1;
               if (left_q == 0) begin
                  r.event_end = 1'b1;
                  phase = AWAIT_STATUS;
               end
            end
            META_TYPE: phase = LEN_VLQ;
            LEN_VLQ: begin
               vlq_acc = {vlq_acc[20:0], b[6:0]};
               if (!b[7]) begin
                  if (vlq_acc == 0) begin
                     r.event_end = 1'b1;
                     phase = AWAIT_STATUS;
                  end else begin
                     left_q = vlq_acc;
                     phase = BODY_BYTES;
                  end
                  vlq_seen = '0;
               end else if (vlq_seen + 1 >= MaxVlqBytes) begin
                  r.error_code = ERR_VLQ_LEN;
                  phase = AWAIT_STATUS;
                  vlq_seen = '0;
               end else begin
                  vlq_seen = vlq_seen + 3'd1;
               end
            end
            default: phase = AWAIT_STATUS;
         endcase
      end
      r.event_kind = kind_q;
      r.event_length = len_q;
      return r;
   endfunction

   task automatic check_field(input string field, input logic [28:0] exp_v,
                              input logic [28:0] got_v);
      if (got_v !== exp_v) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", field, exp_v, got_v);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         phase = AWAIT_STATUS;
         kind_q = KIND_CHAN3;
         left_q = '0;
         vlq_acc = '0;
         vlq_seen = '0;
         len_q = '0;
         framed_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (framed_q.size() == 0) begin
               $error("result item with nothing expected: echo 0x%0h", rsp_echo_byte);
               mismatches++;
            end else begin
               want = framed_q.pop_front();
               check_field("echo_byte", 29'(want.echo_byte), 29'(rsp_echo_byte));
               check_field("event_start", 29'(want.event_start), 29'(rsp_event_start));
               check_field("event_end", 29'(want.event_end), 29'(rsp_event_end));
               check_field("event_kind", 29'(want.event_kind), 29'(rsp_event_kind));
               check_field("event_length", want.event_length, rsp_event_length);
               check_field("error_code", 29'(want.error_code), 29'(rsp_error_code));
            end
         end
         if (req_valid && req_ready)
            framed_q.push_back(frame_byte(req_data_byte));
      end
      waiting = framed_q.size();
   end

endmodule

[tb/sv/midi_file_event_framer_top_tb.sv]
module midi_file_event_framer_top_tb;

   import mfef_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ItemTarget = 1300;
   localparam int CycleLimit = 1000000;
   localparam int HoldCycles = 300;

   localparam logic [3:0] NoteOff   = 4'h8;
   localparam logic [3:0] NoteOn    = 4'h9;
   localparam logic [3:0] PolyTouch = 4'hA;
   localparam logic [3:0] Control   = 4'hB;
   localparam logic [3:0] Program   = 4'hC;
   localparam logic [3:0] ChanTouch = 4'hD;
   localparam logic [3:0] PitchBend = 4'hE;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_echo_byte;
   logic        rsp_event_start;
   logic        rsp_event_end;
   logic [1:0]  rsp_event_kind;
   logic [28:0] rsp_event_length;
   logic [1:0]  rsp_error_code;

   int failures;
   int pending;
   int sent = 0;
   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;
   bit hold_rsp = 1'b0;
   bit held_once = 1'b0;

   logic [3:0] chan3_hi[5] = '{NoteOff, NoteOn, PolyTouch, Control, PitchBend};

   logic [7:0] opening_q[$] = '{
      8'h90, 8'h3C, 8'h7F,
      8'hEF, 8'hFF, 8'h80,
      8'hC5, 8'h00,
      8'h00, 8'h7F, 8'hF1, 8'hFE,
      SysexF0, 8'h02, 8'h00, 8'hFF,
      SysexF7, 8'h00,
      MetaFF, 8'h2F, 8'h00,
      MetaFF, 8'h7F, 8'h81, 8'h80, 8'h80, 8'h80
   };

   midi_file_event_framer_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_echo_byte    (rsp_echo_byte),
      .rsp_event_start  (rsp_event_start),
      .rsp_event_end    (rsp_event_end),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_event_length (rsp_event_length),
      .rsp_error_code   (rsp_error_code)
   );

   midi_frame_monitor mon (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_echo_byte    (rsp_echo_byte),
      .rsp_event_start  (rsp_event_start),
      .rsp_event_end    (rsp_event_end),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_event_length (rsp_event_length),
      .rsp_error_code   (rsp_error_code),
      .mismatch_count   (failures),
      .waiting_count    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (CycleLimit) @(posedge clock);
      $display("FAIL midi_file_event_framer_top");
      $finish;
   end

   function automatic int idle_len(input bit calm);
      int r;
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] body_byte();
      if ($urandom_range(0, 9) == 0)
         return 8'($urandom_range(128, 255));
      return 8'($urandom_range(0, 127));
   endfunction

   function automatic int pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85)
         return $urandom_range(0, 12);
      if (r < 98)
         return $urandom_range(13, 200);
      return $urandom_range(201, 600);
   endfunction

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = idle_len(req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data_byte <= b;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sent++;
      @(negedge clock);
   endtask

   task automatic random_event();
      logic [7:0] ev[$];
      int pick;
      int n;
      int len;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         ev.push_back({chan3_hi[$urandom_range(0, 4)], 4'($urandom)});
         ev.push_back(body_byte());
         ev.push_back(body_byte());
      end else if (pick < 50) begin
         ev.push_back({$urandom_range(0, 1) ? Program : ChanTouch, 4'($urandom)});
         ev.push_back(body_byte());
      end else if (pick < 85) begin
         if ($urandom_range(0, 1)) begin
            ev.push_back($urandom_range(0, 1) ? SysexF0 : SysexF7);
         end else begin
            ev.push_back(MetaFF);
            ev.push_back(8'($urandom));
         end
         len = pick_length();
         n = (len < 128) ? 1 : 2;
         // padded VLQ: leading zero groups keep lengths short
         if ($urandom_range(0, 3) == 0)
            n = $urandom_range(n, MaxVlqBytes);
         for (int i = n - 1; i >= 0; i--)
            ev.push_back({1'(i != 0), 7'(len >> (7 * i))});
         repeat (len) ev.push_back(8'($urandom));
      end else if (pick < 92) begin
         if ($urandom_range(0, 1))
            ev.push_back(8'($urandom_range(0, 127)));
         else
            ev.push_back(8'($urandom_range(241, 254)));
      end else if (pick < 97) begin
         if ($urandom_range(0, 1)) begin
            ev.push_back($urandom_range(0, 1) ? SysexF0 : SysexF7);
         end else begin
            ev.push_back(MetaFF);
            ev.push_back(8'($urandom));
         end
         repeat (MaxVlqBytes) ev.push_back({1'b1, 7'($urandom)});
      end else begin
         repeat ($urandom_range(1, 5)) ev.push_back(8'($urandom));
      end
      foreach (ev[i])
         send_byte(ev[i]);
   endtask

   initial begin
      int stall;
      rsp_ready = 1'b0;
      wait (!reset);
      forever begin
         if ($urandom_range(0, 31) == 0)
            rsp_calm = !rsp_calm;
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (HoldCycles) @(negedge clock);
            hold_rsp = 1'b0;
         end else begin
            stall = idle_len(rsp_calm);
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(negedge clock);
            end
         end
         rsp_ready <= 1'b1;
         @(negedge clock);
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = 8'h00;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (opening_q[i])
         send_byte(opening_q[i]);
      while (sent < ItemTarget) begin
         if ($urandom_range(0, 19) == 0)
            req_calm = !req_calm;
         if (!held_once && sent >= 500) begin
            // long output stall while input keeps coming
            held_once = 1'b1;
            hold_rsp = 1'b1;
            req_calm = 1'b1;
         end
         random_event();
      end
      req_valid <= 1'b0;
      wait (pending == 0);
      repeat (10) @(negedge clock);
      if (failures == 0)
         $display("PASS midi_file_event_framer_top");
      else
         $display("FAIL midi_file_event_framer_top");
      $finish;
   end

endmodule
